// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the scanner modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define SLMS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed: lbl");

// The consequent holds in the same cycle as the antecedent.
`define SLMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// The consequent holds in the cycle after the antecedent.
`define SLMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define SLMS_ASSERT(lbl, expr)
`define SLMS_ASSERT_IMP(lbl, ante, cons)
`define SLMS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/slms_pkg.sv =====
// ---------------------------------------------------------------------------
// slms_pkg
// Types, constants and helpers shared by the LED matrix scanner modules.
// ---------------------------------------------------------------------------
package slms_pkg;

  // Depth of the pattern store. It must be a power of two from 16 to 4096.
  localparam int unsigned PATTERN_DEPTH = 128;
  localparam int unsigned PatAw         = $clog2(PATTERN_DEPTH);
  localparam int unsigned WideW         = PatAw + 8;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCROLL_PERIOD = 2'd0,
    CFG_SCROLL_STEP   = 2'd1,
    CFG_LAST_OFFSET   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] scroll_period;
    logic [3:0]  scroll_step;
    logic [6:0]  last_offset;
  } cfg_t;

  // One scan job handed from the front to the back.
  typedef struct packed {
    logic [7:0] pattern;
    logic [2:0] column;
  } job_t;

  // Status of the job queue seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  // Reduces an address modulo the (power of two) store depth.
  function automatic logic [PatAw-1:0] pat_index(input logic [7:0] addr);
    logic [WideW-1:0] wide;
    wide = WideW'(addr);
    return wide[PatAw-1:0];
  endfunction

endpackage

// ===== rtl/slms_front.sv =====
// ---------------------------------------------------------------------------
// slms_front
// Accepts input beats, stores pattern bytes, keeps the scroll state and
// reads the pattern for each refresh tick into a job for the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slms_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slms_pkg::cfg_t     cfg_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic [0:0]         opcode_i,
  input  logic [6:0]         pattern_address_i,
  input  logic [7:0]         pattern_byte_i,
  input  slms_pkg::qstat_t   qstat_i,
  output logic               job_push_o,
  output slms_pkg::job_t     job_o
);
  import slms_pkg::*;

  logic [7:0]       pattern_mem_q [PATTERN_DEPTH];
  logic [7:0]       rdata_q;
  logic [2:0]       s1_col_q;
  logic             s1_valid_q, s1_valid_d;
  logic [2:0]       col_q, col_d;
  logic [15:0]      tick_q, tick_d;
  logic [6:0]       offset_q, offset_d;

  logic             accept, is_tick, wr_en, s1_go;
  logic [15:0]      tick_inc;
  logic [7:0]       off_next;
  logic [7:0]       rd_sum;

  // A tick waiting for queue room blocks further beats.
  assign s1_go   = s1_valid_q && !qstat_i.full;
  assign full_o  = s1_valid_q && qstat_i.full;
  assign accept  = push_i && !full_o;
  assign is_tick = (op_e'(opcode_i) == OP_TICK);
  assign wr_en   = accept && !is_tick;

  always_comb begin
    tick_inc = tick_q + 16'd1;
    tick_d   = tick_inc;
    offset_d = offset_q;
    off_next = {1'b0, offset_q} + {4'b0000, cfg_i.scroll_step};
    if (tick_inc > cfg_i.scroll_period) begin
      tick_d   = 16'd0;
      offset_d = (off_next > {1'b0, cfg_i.last_offset}) ? 7'd0 : off_next[6:0];
    end
    col_d      = col_q + 3'd1;
    rd_sum     = {5'b00000, col_q} + {1'b0, offset_d};
    s1_valid_d = (accept && is_tick) || (s1_valid_q && !s1_go);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= 3'd0;
      tick_q     <= 16'd0;
      offset_q   <= 7'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept && is_tick) begin
        col_q    <= col_d;
        tick_q   <= tick_d;
        offset_q <= offset_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pattern_mem_q[pat_index({1'b0, pattern_address_i})] <= pattern_byte_i;
    end
    if (accept && is_tick) begin
      rdata_q  <= pattern_mem_q[pat_index(rd_sum)];
      s1_col_q <= col_q;
    end
  end

  assign job_push_o     = s1_go;
  assign job_o.pattern  = rdata_q;
  assign job_o.column   = s1_col_q;

  `SLMS_ASSERT_NXT(a_stalled_job_holds, s1_valid_q && !s1_go,
                   s1_valid_q && $stable(rdata_q) && $stable(s1_col_q))
  `SLMS_ASSERT_IMP(a_full_only_when_busy, full_o, s1_valid_q)

endmodule

// ===== rtl/slms_queue.sv =====
// ---------------------------------------------------------------------------
// slms_queue
// Two-entry job queue between the front and the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slms_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slms_pkg::job_t     job_i,
  input  logic               pop_i,
  output slms_pkg::job_t     job_o,
  output slms_pkg::qstat_t   qstat_o
);
  import slms_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.valid = (count_q != 2'd0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && qstat_o.valid;
  assign job_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= job_i;
  end

  `SLMS_ASSERT(a_count_bounded, count_q != 2'd3)
  `SLMS_ASSERT_IMP(a_ptrs_match_count, count_q == 2'd0 || count_q == 2'd2,
                   wr_ptr_q == rd_ptr_q)

endmodule

// ===== rtl/slms_back.sv =====
// ---------------------------------------------------------------------------
// slms_back
// Shifts each job out as eight serial beats into the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slms_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slms_pkg::qstat_t   qstat_i,
  input  slms_pkg::job_t     job_i,
  output logic               job_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [0:0]         serial_bit_o,
  output logic [0:0]         latch_strobe_o,
  output logic [7:0]         column_drive_o
);
  import slms_pkg::*;

  logic       busy_q, out_valid_q;
  logic [2:0] cnt_q;
  logic [7:0] sh_q;
  logic [2:0] col_q;
  logic [0:0] bit_q, latch_q;
  logic [7:0] drive_q;
  logic       out_free, emit, last, take;

  assign out_free  = !out_valid_q || pop_i;
  assign emit      = busy_q && out_free;
  assign last      = (cnt_q == 3'd7);
  assign take      = qstat_i.valid && (!busy_q || (emit && last));
  assign job_pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (emit) begin
        if (last) busy_q <= 1'b0;
        cnt_q <= cnt_q + 3'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sh_q  <= job_i.pattern;
      col_q <= job_i.column;
    end else if (emit) begin
      sh_q <= {sh_q[6:0], 1'b0};
    end
    if (emit) begin
      bit_q   <= sh_q[7];
      latch_q <= last;
      drive_q <= last ? ~(8'h80 >> col_q) : 8'hff;
    end
  end

  assign empty_o        = !out_valid_q;
  assign serial_bit_o   = bit_q;
  assign latch_strobe_o = latch_q;
  assign column_drive_o = drive_q;

  `SLMS_ASSERT_IMP(a_latch_drives_one, out_valid_q && latch_q[0],
                   $countones(~drive_q) == 1)
  `SLMS_ASSERT_IMP(a_blank_while_shift, out_valid_q && !latch_q[0], drive_q == 8'hff)

endmodule

// ===== rtl/scrolling_led_matrix_scanner.sv =====
// ---------------------------------------------------------------------------
// scrolling_led_matrix_scanner
// Scans an 8x8 LED matrix with horizontal scrolling, one serial bit a beat.
// ---------------------------------------------------------------------------
// Usage. Input beats are pushed with push_i while full_o is low. A beat with
// opcode 0 stores pattern_byte_i at pattern_address_i and gives no result.
// A beat with opcode 1 is a refresh tick: it advances the tick and scroll
// state and yields eight result beats, the pattern byte most significant
// bit first, with the columns blanked; the eighth beat raises latch_strobe_o
// and drives the active column low. Results are read like a queue: while
// empty_o is low the oldest result stands on the ports and pop_i takes it.
// The first result of a tick passes the read stage, the job queue and the
// shifter; the rest follow one per cycle unless the receiver stalls. The
// one-bit-per-cycle shifter in the back end sets the tick rate. The front
// keeps accepting pattern writes and further ticks while the shifter runs,
// until its two-entry job queue and read stage fill; then full_o rises.
// When the receiver stalls, the result register holds and the shifter
// waits. Reset clears the scroll state, the column and all queues and
// restores the register defaults; the pattern store itself is not cleared
// and must be written before it is shown. The configuration channel is
// always ready and is meant to be written while the block is idle.
// ---------------------------------------------------------------------------
module scrolling_led_matrix_scanner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [slms_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [0:0]                    opcode_i,
  input  logic [6:0]                    pattern_address_i,
  input  logic [7:0]                    pattern_byte_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [0:0]                    serial_bit_o,
  output logic [0:0]                    latch_strobe_o,
  output logic [7:0]                    column_drive_o
);
  import slms_pkg::*;

  cfg_t   cfg_q;
  job_t   front_job, queue_job;
  qstat_t qstat;
  logic   job_push, job_pop;

  // Configuration registers; writes to an index beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_period <= 16'd100;
      cfg_q.scroll_step   <= 4'd1;
      cfg_q.last_offset   <= 7'd59;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SCROLL_PERIOD: cfg_q.scroll_period <= cfg_data_i;
        CFG_SCROLL_STEP:   cfg_q.scroll_step   <= cfg_data_i[3:0];
        CFG_LAST_OFFSET:   cfg_q.last_offset   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // The front takes beats, owns the pattern store and builds scan jobs.
  slms_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .push_i            (push_i),
    .full_o            (full_o),
    .opcode_i          (opcode_i),
    .pattern_address_i (pattern_address_i),
    .pattern_byte_i    (pattern_byte_i),
    .qstat_i           (qstat),
    .job_push_o        (job_push),
    .job_o             (front_job)
  );

  // A short queue decouples job building from shifting.
  slms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (front_job),
    .pop_i   (job_pop),
    .job_o   (queue_job),
    .qstat_o (qstat)
  );

  // The back shifts each job out into the result register.
  slms_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .qstat_i        (qstat),
    .job_i          (queue_job),
    .job_pop_o      (job_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .serial_bit_o   (serial_bit_o),
    .latch_strobe_o (latch_strobe_o),
    .column_drive_o (column_drive_o)
  );

endmodule

// ===== tb/scan_check_pkg.sv =====
// ---------------------------------------------------------------------------
// scan_check_pkg
// Predicts the scanner's serial beats and checks them as they leave.
// ---------------------------------------------------------------------------
package scan_check_pkg;

  import slms_pkg::*;

  // One result beat as it appears on the scanner's output ports.
  typedef struct packed {
    logic       serial;
    logic       strobe;
    logic [7:0] drive;
  } scan_beat_t;

  class scan_checker;

    logic [15:0] scroll_period;
    logic [3:0]  scroll_step;
    logic [6:0]  last_offset;

    logic [2:0]  column;
    logic [15:0] tick_count;
    logic [6:0]  scroll_offset;
    logic [7:0]  pattern_store [PATTERN_DEPTH];
    bit          loaded [PATTERN_DEPTH];

    scan_beat_t  expected_beats [$];
    int unsigned errors;

    function new();
      scroll_period = 16'd100;
      scroll_step   = 4'd1;
      last_offset   = 7'd59;
      column        = '0;
      tick_count    = '0;
      scroll_offset = '0;
      errors        = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void configure(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_SCROLL_PERIOD: scroll_period = value;
        CFG_SCROLL_STEP:   scroll_step   = value[3:0];
        CFG_LAST_OFFSET:   last_offset   = value[6:0];
        default: ;
      endcase
    endfunction

    // Offset after one scroll advance; the sum is compared at full width.
    function logic [6:0] advanced_offset();
      logic [7:0] sum;
      sum = {1'b0, scroll_offset} + {4'd0, scroll_step};
      return (sum > {1'b0, last_offset}) ? 7'd0 : sum[6:0];
    endfunction

    // Store entry that the next tick will read, leaving the state untouched.
    function logic [6:0] next_read_address();
      logic [15:0] ticks;
      logic [6:0]  offset;
      ticks  = tick_count + 16'd1;
      offset = scroll_offset;
      if (ticks > scroll_period) offset = advanced_offset();
      return 7'({4'd0, column} + offset);
    endfunction

    function void accept_item(op_e op, logic [6:0] addr, logic [7:0] data);
      scan_beat_t beat;
      logic [7:0] row;
      if (op == OP_WRITE) begin
        pattern_store[addr] = data;
        loaded[addr]        = 1'b1;
        return;
      end
      tick_count = tick_count + 16'd1;
      if (tick_count > scroll_period) begin
        tick_count    = '0;
        scroll_offset = advanced_offset();
      end
      row = pattern_store[7'({4'd0, column} + scroll_offset)];
      for (int k = 7; k >= 0; k--) begin
        beat.serial = row[k];
        beat.strobe = (k == 0);
        beat.drive  = (k == 0) ? ~(8'h80 >> column) : 8'hff;
        expected_beats.push_back(beat);
      end
      column = column + 3'd1;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void check_beat(logic serial, logic strobe, logic [7:0] drive);
      scan_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: serial %0d strobe %0d drive %h", serial, strobe, drive);
        return;
      end
      want = expected_beats.pop_front();
      if (serial !== want.serial || strobe !== want.strobe || drive !== want.drive) begin
        errors++;
        if (errors <= 10)
          $display("beat mismatch: expected serial %0d strobe %0d drive %h, got %0d %0d %h",
                   want.serial, want.strobe, want.drive, serial, strobe, drive);
      end
    endfunction

  endclass

endpackage

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives pattern writes and refresh ticks into the LED matrix scanner and
// checks every serial beat against a cycle-free prediction of the scan.
// ---------------------------------------------------------------------------
module testbench;

  import slms_pkg::*;
  import scan_check_pkg::*;

  // Generous ceiling on the length of the whole run.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned HOLD_CYCLES  = 400;
  // Settling time after the last beat, so that a trailing pattern write
  // has certainly landed before the registers change.
  localparam int unsigned QUIET_CYCLES = 12;

  localparam logic [7:0] DIRECTED_ROWS [8] = '{
    8'h00, 8'hff, 8'h80, 8'h01, 8'ha5, 8'h5a, 8'h7f, 8'hfe
  };

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                cfg_valid_i       = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i       = '0;
  logic [CfgDataW-1:0] cfg_data_i        = '0;
  logic                push_i            = 1'b0;
  logic                full_o;
  logic [0:0]          opcode_i          = '0;
  logic [6:0]          pattern_address_i = '0;
  logic [7:0]          pattern_byte_i    = '0;
  logic                empty_o;
  logic                pop_i             = 1'b0;
  logic [0:0]          serial_bit_o;
  logic [0:0]          latch_strobe_o;
  logic [7:0]          column_drive_o;

  // Idling odds in percent per cycle, changed by the main flow per phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // The hold-off is requested by a one-cycle kick and timed by its own
  // process, so the sender carries on offering beats meanwhile.
  logic        hold_kick      = 1'b0;
  logic        receiver_held  = 1'b0;
  int unsigned cycle_count    = 0;

  scan_checker board = new();

  scrolling_led_matrix_scanner uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .push_i            (push_i),
    .full_o            (full_o),
    .opcode_i          (opcode_i),
    .pattern_address_i (pattern_address_i),
    .pattern_byte_i    (pattern_byte_i),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .serial_bit_o      (serial_bit_o),
    .latch_strobe_o    (latch_strobe_o),
    .column_drive_o    (column_drive_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog: a run that has not finished by now has lost a beat or hung.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver. Outputs are sampled at the edge, before the block updates,
  // and a beat counts as taken when pop_i was high and empty_o low there.
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o)
      board.check_beat(serial_bit_o, latch_strobe_o, column_drive_o);
    pop_i <= !receiver_held && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_kick) begin
        receiver_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        receiver_held <= 1'b0;
      end
    end
  end

  // Offers one input beat and returns at the edge where it is taken. Push
  // is left high so that back-to-back beats follow without a gap.
  task automatic send(input op_e op, input logic [6:0] addr, input logic [7:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i            <= 1'b1;
    opcode_i          <= op;
    pattern_address_i <= addr;
    pattern_byte_i    <= data;
    do @(posedge clk_i); while (full_o);
    board.accept_item(op, addr, data);
  endtask

  // Writes all three registers in consecutive beats; only used while the
  // block is idle.
  task automatic set_scan_config(input logic [15:0] period, input logic [15:0] step,
                                 input logic [15:0] last);
    cfg_idx_e    regs [3];
    logic [15:0] values [3];
    regs   = '{CFG_SCROLL_PERIOD, CFG_SCROLL_STEP, CFG_LAST_OFFSET};
    values = '{period, step, last};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= values[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.configure(regs[i], values[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering beats and waits until every predicted beat has been
  // taken, then lets the block settle.
  task automatic drain_results();
    push_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Random mix of pattern writes and ticks. A tick that would show a
  // never-written store entry is preceded by a write to that entry, so the
  // undefined contents of the store are never put on the display.
  task automatic random_items(input int unsigned count, input int unsigned send_pct,
                              input int unsigned recv_pct);
    logic [6:0] addr;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      if ($urandom_range(99) < 35) begin
        send(OP_WRITE, 7'($urandom), 8'($urandom));
      end else begin
        addr = board.next_read_address();
        if (!board.loaded[addr]) send(OP_WRITE, addr, 8'($urandom));
        send(OP_TICK, 7'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: extreme row patterns in the
    // first eight columns plus the top store entry, then a full sweep of
    // ticks so that the column wraps from 7 back to 0. Alternate ticks carry
    // all-ones in the fields that a tick ignores.
    for (int i = 0; i < 8; i++) send(OP_WRITE, 7'(i), DIRECTED_ROWS[i]);
    send(OP_WRITE, 7'h7f, 8'hc3);
    for (int i = 0; i < 9; i++)
      send(OP_TICK, (i % 2 == 1) ? 7'h7f : 7'h00, (i % 2 == 1) ? 8'hff : 8'h00);
    drain_results();

    // Scroll on every tick with an odd step and the widest offset range, so
    // that column plus offset runs past the end of the store.
    set_scan_config(16'd0, 16'd9, 16'd127);
    random_items(45, 0, 0);
    drain_results();

    // Last offset lowered below the current offset, with a zero step: the
    // stale offset is shown until the next advance clears it.
    set_scan_config(16'd2, 16'd0, 16'd0);
    random_items(35, 88, 0);
    drain_results();

    // Longest period, so the offset stays put; the receiver stalls a lot.
    set_scan_config(16'd65535, 16'd8, 16'd120);
    random_items(35, 0, 88);
    drain_results();

    // Largest step the register holds.
    set_scan_config(16'd1, 16'd15, 16'd60);
    random_items(45, 28, 28);
    drain_results();

    // Back pressure: the receiver holds off for a long stretch while ticks
    // keep coming, so the block fills and raises full_o. The drain after it
    // is the sender pausing until every beat has been taken.
    set_scan_config(16'd0, 16'd1, 16'd7);
    hold_kick <= 1'b1;
    @(posedge clk_i);
    hold_kick <= 1'b0;
    random_items(40, 0, 0);
    drain_results();
    random_items(40, 28, 28);
    drain_results();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/slms_pkg.sv
rtl/slms_front.sv
rtl/slms_queue.sv
rtl/slms_back.sv
rtl/scrolling_led_matrix_scanner.sv
tb/scan_check_pkg.sv
tb/testbench.sv
